// ===== hw/rtl/frd_pkg.sv =====
// shared types and constants for the flood relay duplicate suppressor
// no dependencies; every other file of the block imports this package
package frd_pkg;

  localparam int SEEN_DEPTH_DEF  = 32;
  localparam int HEARD_DEPTH_DEF = 32;
  localparam int ID_BITS_DEF     = 32;

  localparam int ID_W  = 32;
  localparam int CNT_W = 32;
  localparam int HOP_W = 8;
  localparam int DLY_W = 10;
  localparam int EV_W  = 3;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_RECV = 1'b1
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE       = 3'd0,
    EV_SENT       = 3'd1,
    EV_SKIPPED    = 3'd2,
    EV_SCHED      = 3'd3,
    EV_DUP_DROP   = 3'd4,
    EV_DUP_CANCEL = 3'd5,
    EV_EXPIRED    = 3'd6,
    EV_IGNORED    = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_LAST,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic   load_item;
    logic   heard_wr;
    logic   seen_wr;
    logic   scan_clr;
    logic   scan_rd;
    logic   commit;
    event_t ev;
    logic   pend_set;
    logic   pend_clr;
    logic   pend_dec;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pend_valid;
    logic due;
    logic bad;
    logic hop_gt1;
    logic match;
    logic pend_eq;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/frd_ring.sv =====
// ring of message triples with per-entry valid bits and a registered read port
// depends on frd_pkg for field widths
module frd_ring
  import frd_pkg::*;
#(
  parameter int DEPTH = SEEN_DEPTH_DEF,
  parameter int SW    = ID_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [SW-1:0]    wr_sender,
  input  logic [CNT_W-1:0] wr_count,
  input  logic [HOP_W-1:0] wr_hops,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic             rd_valid,
  output logic [SW-1:0]    rd_sender,
  output logic [CNT_W-1:0] rd_count,
  output logic [HOP_W-1:0] rd_hops
);

  logic [SW-1:0]    mem_sender [DEPTH];
  logic [CNT_W-1:0] mem_count  [DEPTH];
  logic [HOP_W-1:0] mem_hops   [DEPTH];
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic             rd_valid_r;

  always_comb begin
    valid_nxt = valid_r;
    ptr_nxt   = ptr_r;
    if (wr_en) begin
      valid_nxt[ptr_r] = 1'b1;
      ptr_nxt = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      ptr_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
      if (rd_en) rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_sender[ptr_r] <= wr_sender;
      mem_count[ptr_r]  <= wr_count;
      mem_hops[ptr_r]   <= wr_hops;
    end
    if (rd_en) begin
      rd_sender <= mem_sender[rd_addr];
      rd_count  <= mem_count[rd_addr];
      rd_hops   <= mem_hops[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;

endmodule

// ===== hw/rtl/frd_ctrl.sv =====
// controller state machine: sequences decide, ring scan and commit
// depends on frd_pkg for state, command and status types
module frd_ctrl
  import frd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.ev    = EV_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.op == OP_TICK) begin
          if (sts.pend_valid && sts.due) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end else if (sts.out_free) begin
            // countdown step or nothing pending
            cmd.commit   = 1'b1;
            cmd.ev       = EV_NONE;
            cmd.pend_dec = sts.pend_valid;
            state_nxt    = ST_IDLE;
          end
        end else if (sts.bad) begin
          if (sts.out_free) begin
            cmd.heard_wr = 1'b1;
            cmd.commit   = 1'b1;
            cmd.ev       = EV_IGNORED;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.heard_wr = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        // last read entry is compared in this cycle
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
          if (sts.op == OP_TICK) begin
            cmd.ev       = sts.match ? EV_SKIPPED : EV_SENT;
            cmd.pend_clr = 1'b1;
          end else if (sts.match) begin
            if (sts.pend_valid && sts.pend_eq) begin
              cmd.ev       = EV_DUP_CANCEL;
              cmd.pend_clr = 1'b1;
            end else begin
              cmd.ev = EV_DUP_DROP;
            end
          end else begin
            cmd.seen_wr = 1'b1;
            if (sts.hop_gt1) begin
              cmd.ev       = EV_SCHED;
              cmd.pend_set = 1'b1;
            end else begin
              cmd.ev = EV_EXPIRED;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/frd_dp.sv =====
// datapath: item registers, seen and heard rings, scan counter, pending relay
// and the output register; depends on frd_pkg and frd_ring
module frd_dp
  import frd_pkg::*;
#(
  parameter int SEEN_DEPTH  = SEEN_DEPTH_DEF,
  parameter int HEARD_DEPTH = HEARD_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_operation,
  input  logic [ID_W-1:0]  in_sender_id,
  input  logic [CNT_W-1:0] in_message_count,
  input  logic [HOP_W-1:0] in_hop_limit,
  input  logic             in_message_ok,
  input  logic [DLY_W-1:0] in_relay_delay,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [EV_W-1:0]  out_event_res,
  output logic [ID_W-1:0]  out_sender,
  output logic [CNT_W-1:0] out_count,
  output logic [HOP_W-1:0] out_hop_limit
);

  // only the low ID_BITS of the sender are kept
  localparam int SB  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int SAW = $clog2(SEEN_DEPTH);
  localparam int HAW = $clog2(HEARD_DEPTH);
  localparam int IW  = (SAW > HAW) ? SAW : HAW;

  op_t              op_r;
  logic [SB-1:0]    snd_r;
  logic [CNT_W-1:0] cnt_r;
  logic [HOP_W-1:0] hop_r;
  logic             ok_r;
  logic [DLY_W-1:0] dly_r;

  logic             pv_r, pv_nxt;
  logic [SB-1:0]    ps_r, ps_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic [HOP_W-1:0] ph_r, ph_nxt;
  logic [DLY_W-1:0] rem_r, rem_nxt;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic             cmp_en_r;
  logic             match_r, match_nxt;

  logic             ov_r, ov_nxt;
  logic [EV_W-1:0]  ev_r;
  logic [ID_W-1:0]  os_r;
  logic [CNT_W-1:0] oc_r;
  logic [HOP_W-1:0] oh_r;
  logic [ID_W-1:0]  os_nxt;
  logic [CNT_W-1:0] oc_nxt;
  logic [HOP_W-1:0] oh_nxt;

  logic             s_v, h_v;
  logic [SB-1:0]    s_s, h_s;
  logic [CNT_W-1:0] s_c, h_c;
  logic [HOP_W-1:0] s_h, h_h;
  logic             sel_heard, hit, scan_last;
  logic [HOP_W-1:0] hop_dec;

  frd_ring #(.DEPTH(SEEN_DEPTH), .SW(SB)) u_seen (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd.seen_wr),
    .wr_sender (snd_r),
    .wr_count  (cnt_r),
    .wr_hops   (hop_r),
    .rd_en     (cmd.scan_rd),
    .rd_addr   (idx_r[SAW-1:0]),
    .rd_valid  (s_v),
    .rd_sender (s_s),
    .rd_count  (s_c),
    .rd_hops   (s_h)
  );

  frd_ring #(.DEPTH(HEARD_DEPTH), .SW(SB)) u_heard (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd.heard_wr),
    .wr_sender (snd_r),
    .wr_count  (cnt_r),
    .wr_hops   (hop_r),
    .rd_en     (cmd.scan_rd),
    .rd_addr   (idx_r[HAW-1:0]),
    .rd_valid  (h_v),
    .rd_sender (h_s),
    .rd_count  (h_c),
    .rd_hops   (h_h)
  );

  // ticks check the pending relay against heard, headers check against seen
  assign sel_heard = (op_r == OP_TICK);
  assign hop_dec   = hop_r - 1'b1;

  always_comb begin
    if (sel_heard) begin
      hit       = h_v && (h_s == ps_r) && (h_c == pc_r) && (h_h == ph_r);
      scan_last = (idx_r == IW'(HEARD_DEPTH - 1));
    end else begin
      hit       = s_v && (s_s == snd_r) && (s_c == cnt_r) && (s_h == hop_r);
      scan_last = (idx_r == IW'(SEEN_DEPTH - 1));
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    match_nxt = match_r;
    if (cmd.scan_clr) begin
      idx_nxt   = '0;
      match_nxt = 1'b0;
    end else begin
      if (cmd.scan_rd) idx_nxt = idx_r + 1'b1;
      if (cmp_en_r && hit) match_nxt = 1'b1;
    end
  end

  always_comb begin
    pv_nxt  = pv_r;
    ps_nxt  = ps_r;
    pc_nxt  = pc_r;
    ph_nxt  = ph_r;
    rem_nxt = rem_r;
    if (cmd.pend_set) begin
      pv_nxt  = 1'b1;
      ps_nxt  = snd_r;
      pc_nxt  = cnt_r;
      ph_nxt  = hop_dec;
      rem_nxt = dly_r;
    end else if (cmd.pend_clr) begin
      pv_nxt = 1'b0;
      if (sel_heard) rem_nxt = '0;
    end else if (cmd.pend_dec) begin
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_comb begin
    os_nxt = ID_W'(snd_r);
    oc_nxt = cnt_r;
    oh_nxt = '0;
    unique case (cmd.ev)
      EV_NONE: begin
        os_nxt = '0;
        oc_nxt = '0;
      end
      EV_SENT, EV_SKIPPED: begin
        os_nxt = ID_W'(ps_r);
        oc_nxt = pc_r;
        oh_nxt = ph_r;
      end
      EV_SCHED: oh_nxt = hop_dec;
      EV_DUP_DROP, EV_DUP_CANCEL, EV_EXPIRED, EV_IGNORED: oh_nxt = '0;
      default: oh_nxt = '0;
    endcase
  end

  assign ov_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= 1'b0;
      ps_r     <= '0;
      pc_r     <= '0;
      ph_r     <= '0;
      rem_r    <= '0;
      idx_r    <= '0;
      cmp_en_r <= 1'b0;
      match_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      pv_r     <= pv_nxt;
      ps_r     <= ps_nxt;
      pc_r     <= pc_nxt;
      ph_r     <= ph_nxt;
      rem_r    <= rem_nxt;
      idx_r    <= idx_nxt;
      cmp_en_r <= cmd.scan_rd;
      match_r  <= match_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= op_t'(in_operation);
      snd_r <= in_sender_id[SB-1:0];
      cnt_r <= in_message_count;
      hop_r <= in_hop_limit;
      ok_r  <= in_message_ok;
      dly_r <= in_relay_delay;
    end
    if (cmd.commit) begin
      ev_r <= cmd.ev;
      os_r <= os_nxt;
      oc_r <= oc_nxt;
      oh_r <= oh_nxt;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.pend_valid = pv_r;
    sts.due        = (rem_r <= DLY_W'(1));
    sts.bad        = !ok_r || (hop_r == '0);
    sts.hop_gt1    = (hop_r > HOP_W'(1));
    sts.match      = match_r;
    sts.pend_eq    = (ps_r == snd_r) && (pc_r == cnt_r) && (ph_r == hop_r);
    sts.scan_last  = scan_last;
    sts.out_free   = !ov_r || out_ready;
  end

  assign out_valid     = ov_r;
  assign out_event_res = ev_r;
  assign out_sender    = os_r;
  assign out_count     = oc_r;
  assign out_hop_limit = oh_r;

endmodule

// ===== hw/rtl/flood_relay_duplicate_suppressor_unit.sv =====
// flood relay duplicate suppressor, one result transaction per input transaction
// a tick that is not due or a bad header commits from the decide state once the output register is
// free; a valid header scans SEEN_DEPTH entries of the seen ring and a due tick HEARD_DEPTH entries
// of the heard ring, one ring entry per cycle through its read port, before the result is resolved
// a new item is taken only after the last one is committed; the next item is taken while a result waits
// reset: synchronous active-low rst_n clears valid bits, ring pointers and pending relay
module flood_relay_duplicate_suppressor_unit
  import frd_pkg::*;
#(
  parameter int SEEN_DEPTH  = SEEN_DEPTH_DEF,
  parameter int HEARD_DEPTH = HEARD_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_operation,
  input  logic [ID_W-1:0]  in_sender_id,
  input  logic [CNT_W-1:0] in_message_count,
  input  logic [HOP_W-1:0] in_hop_limit,
  input  logic             in_message_ok,
  input  logic [DLY_W-1:0] in_relay_delay,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [EV_W-1:0]  out_event_res,
  output logic [ID_W-1:0]  out_sender,
  output logic [CNT_W-1:0] out_count,
  output logic [HOP_W-1:0] out_hop_limit
);

  cmd_t cmd;
  sts_t sts;

  frd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frd_dp #(
    .SEEN_DEPTH  (SEEN_DEPTH),
    .HEARD_DEPTH (HEARD_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_sender_id     (in_sender_id),
    .in_message_count (in_message_count),
    .in_hop_limit     (in_hop_limit),
    .in_message_ok    (in_message_ok),
    .in_relay_delay   (in_relay_delay),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_sender       (out_sender),
    .out_count        (out_count),
    .out_hop_limit    (out_hop_limit)
  );

  // a result is only loaded when the output register is free
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting transaction");

  // a commit always leaves a transaction on the output
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // no new transaction is taken while a ring scan is running
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> !in_ready)
    else $error("input accepted during scan");

  // pending relay gets at most one update per cycle
  a_pend_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.pend_set, cmd.pend_clr, cmd.pend_dec}))
    else $error("conflicting pending relay updates");

endmodule
